// ===== sv/lvc_pkg.sv =====
// Shared types, constants and helpers of the landing velocity controller.
`default_nettype none
package lvc_pkg;

	localparam int ACC_W = 41;

	localparam logic signed [40:0] NEAR_SQ_LIMIT = 41'sd600000;
	localparam logic signed [15:0] LAND_VZ       = -16'sd400;
	localparam logic signed [23:0] SLOPE_MAX     = 24'sh7FFFFF;
	localparam logic signed [23:0] SLOPE_MIN     = 24'sh800000;
	localparam logic signed [17:0] ERR_MAX       = 18'sh1FFFF;
	localparam logic signed [17:0] ERR_MIN       = 18'sh20000;
	localparam logic [4:0]         SQRT_LAST     = 5'd15;
	localparam logic [4:0]         DIV_LAST      = 5'd23;

	typedef enum logic [1:0] {
		MODE_TICK    = 2'd0,
		MODE_POSE    = 2'd1,
		MODE_GEAR_UP = 2'd2,
		MODE_HOLD    = 2'd3
	} mode_t;

	typedef enum logic [2:0] {
		REG_FAR_THRESHOLD = 3'd0,
		REG_GAIN_NEAR     = 3'd1,
		REG_GAIN_FAR      = 3'd2,
		REG_DERIV_GAIN    = 3'd3,
		REG_XY_LIMIT      = 3'd4,
		REG_Z_LIMIT       = 3'd5,
		REG_LAND_WINDOW   = 3'd6,
		REG_BASE_HEIGHT   = 3'd7
	} reg_idx_t;

	localparam logic [14:0] FAR_THRESHOLD_RST = 15'd4800;
	localparam logic [7:0]  GAIN_NEAR_RST     = 8'd33;
	localparam logic [7:0]  GAIN_FAR_RST      = 8'd128;
	localparam logic [7:0]  DERIV_GAIN_RST    = 8'd26;
	localparam logic [14:0] XY_LIMIT_RST      = 15'd1500;
	localparam logic [14:0] Z_LIMIT_RST       = 15'd1000;
	localparam logic [14:0] LAND_WINDOW_RST   = 15'd100;
	localparam logic [14:0] BASE_HEIGHT_RST   = 15'd3000;

	typedef struct packed {
		logic [14:0] far_threshold_mm;
		logic [7:0]  gain_near_q8;
		logic [7:0]  gain_far_q8;
		logic [7:0]  deriv_gain_q8;
		logic [14:0] xy_speed_limit;
		logic [14:0] z_speed_limit;
		logic [14:0] land_window_mm;
		logic [14:0] base_height_mm;
	} cfg_t;

	typedef enum logic [3:0] {
		OP_IDLE      = 4'd0,
		OP_LOAD      = 4'd1,
		OP_MAC       = 4'd2,
		OP_SQRT_INIT = 4'd3,
		OP_SQRT_STEP = 4'd4,
		OP_PLAN      = 4'd5,
		OP_DIV_STEP  = 4'd6,
		OP_DIV_FIN   = 4'd7,
		OP_VX        = 4'd8,
		OP_VY        = 4'd9,
		OP_ERR       = 4'd10,
		OP_VZ        = 4'd11,
		OP_FIN       = 4'd12
	} op_t;

	typedef enum logic [3:0] {
		SEL_XX = 4'd0,
		SEL_YY = 4'd1,
		SEL_DX = 4'd2,
		SEL_DY = 4'd3,
		SEL_DZ = 4'd4,
		SEL_PX = 4'd5,
		SEL_KX = 4'd6,
		SEL_PY = 4'd7,
		SEL_KY = 4'd8,
		SEL_ZD = 4'd9,
		SEL_EK = 4'd10
	} sel_t;

	typedef struct packed {
		op_t  op;
		sel_t sel;
		logic clr;
	} cmd_t;

	typedef struct packed {
		logic plan_go;
		logic hd_zero;
		logic sqrt_last;
		logic div_last;
	} status_t;

	// Saturate a signed value to +-lim.
	function automatic logic signed [15:0] sat16(input logic signed [23:0] v,
		input logic [14:0] lim);
		logic signed [23:0] lim_s;
		logic signed [15:0] res;
		lim_s = $signed({9'b0, lim});
		if (v > lim_s) begin
			res = $signed({1'b0, lim});
		end else if (v < -lim_s) begin
			res = -$signed({1'b0, lim});
		end else begin
			res = v[15:0];
		end
		return res;
	endfunction

endpackage
`default_nettype wire

// ===== sv/lvc_regs.sv =====
// Configuration register file behind the APB-style port.
`default_nettype none
module lvc_regs (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         psel,
	input  wire logic         penable,
	input  wire logic         pwrite,
	input  wire logic [4:0]   paddr,
	input  wire logic [31:0]  pwdata,
	output logic [31:0]       prdata,
	output logic              pready,
	output lvc_pkg::cfg_t     cfg
);
	lvc_pkg::cfg_t cfg_q;
	lvc_pkg::reg_idx_t idx;

	assign idx = lvc_pkg::reg_idx_t'(paddr[4:2]);
	assign pready = 1'b1;
	assign cfg = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.far_threshold_mm <= lvc_pkg::FAR_THRESHOLD_RST;
			cfg_q.gain_near_q8     <= lvc_pkg::GAIN_NEAR_RST;
			cfg_q.gain_far_q8      <= lvc_pkg::GAIN_FAR_RST;
			cfg_q.deriv_gain_q8    <= lvc_pkg::DERIV_GAIN_RST;
			cfg_q.xy_speed_limit   <= lvc_pkg::XY_LIMIT_RST;
			cfg_q.z_speed_limit    <= lvc_pkg::Z_LIMIT_RST;
			cfg_q.land_window_mm   <= lvc_pkg::LAND_WINDOW_RST;
			cfg_q.base_height_mm   <= lvc_pkg::BASE_HEIGHT_RST;
		end else if (psel && penable && pwrite) begin
			case (idx)
				lvc_pkg::REG_FAR_THRESHOLD: cfg_q.far_threshold_mm <= pwdata[14:0];
				lvc_pkg::REG_GAIN_NEAR:     cfg_q.gain_near_q8     <= pwdata[7:0];
				lvc_pkg::REG_GAIN_FAR:      cfg_q.gain_far_q8      <= pwdata[7:0];
				lvc_pkg::REG_DERIV_GAIN:    cfg_q.deriv_gain_q8    <= pwdata[7:0];
				lvc_pkg::REG_XY_LIMIT:      cfg_q.xy_speed_limit   <= pwdata[14:0];
				lvc_pkg::REG_Z_LIMIT:       cfg_q.z_speed_limit    <= pwdata[14:0];
				lvc_pkg::REG_LAND_WINDOW:   cfg_q.land_window_mm   <= pwdata[14:0];
				lvc_pkg::REG_BASE_HEIGHT:   cfg_q.base_height_mm   <= pwdata[14:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (idx)
			lvc_pkg::REG_FAR_THRESHOLD: prdata = {17'b0, cfg_q.far_threshold_mm};
			lvc_pkg::REG_GAIN_NEAR:     prdata = {24'b0, cfg_q.gain_near_q8};
			lvc_pkg::REG_GAIN_FAR:      prdata = {24'b0, cfg_q.gain_far_q8};
			lvc_pkg::REG_DERIV_GAIN:    prdata = {24'b0, cfg_q.deriv_gain_q8};
			lvc_pkg::REG_XY_LIMIT:      prdata = {17'b0, cfg_q.xy_speed_limit};
			lvc_pkg::REG_Z_LIMIT:       prdata = {17'b0, cfg_q.z_speed_limit};
			lvc_pkg::REG_LAND_WINDOW:   prdata = {17'b0, cfg_q.land_window_mm};
			lvc_pkg::REG_BASE_HEIGHT:   prdata = {17'b0, cfg_q.base_height_mm};
			default:                    prdata = 32'b0;
		endcase
	end
endmodule
`default_nettype wire

// ===== sv/lvc_datapath.sv =====
// Datapath: controller state, shared multiply-accumulate, square root and divider.
`default_nettype none
module lvc_datapath (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  lvc_pkg::cmd_t           cmd,
	output lvc_pkg::status_t        status,
	input  lvc_pkg::cfg_t           cfg,
	input  wire logic [1:0]         mode,
	input  wire logic signed [15:0] pos_x,
	input  wire logic signed [15:0] pos_y,
	input  wire logic signed [15:0] pos_z,
	input  wire logic               tag_lost,
	output logic signed [15:0]      vel_x,
	output logic signed [15:0]      vel_y,
	output logic signed [15:0]      vel_z,
	output logic                    landing_flag
);
	// Model state.
	logic signed [15:0] cur_x_q, cur_y_q, cur_z_q;
	logic signed [15:0] prev_x_q, prev_y_q, prev_z_q;
	logic signed [15:0] held_x_q, held_y_q, held_z_q;
	logic signed [23:0] slope_q;
	logic signed [17:0] last_err_q;
	logic               desc_en_q, plan_done_q, land_q;

	// Working registers.
	logic [1:0]                     mode_q;
	logic                           lost_q;
	logic signed [lvc_pkg::ACC_W-1:0] acc_q;
	logic [31:0]                    sq_n_q;
	logic [17:0]                    sq_rem_q;
	logic [15:0]                    hd_q;
	logic [23:0]                    num_q;
	logic [15:0]                    drem_q;
	logic [23:0]                    quo_q;
	logic                           dz_neg_q;
	logic [4:0]                     cnt_q;
	logic signed [15:0]             vx_q, vy_q;
	logic signed [17:0]             e_q;
	logic signed [15:0]             out_x_q, out_y_q, out_z_q;
	logic                           out_land_q;

	logic signed [16:0] dx, dy, dzp, xe, ye;
	logic [16:0]        abs_x, abs_y;
	logic [7:0]         kp_x, kp_y;
	logic signed [23:0] mul_a, sl;
	logic signed [18:0] mul_b, ediff;
	logic signed [42:0] prod;
	logic signed [lvc_pkg::ACC_W-1:0] acc_d, acc_rnd;
	logic signed [16:0] dz;
	logic [16:0]        abs_dz;
	logic [19:0]        sq_sh, sq_trial, sq_diff;
	logic               sq_ge;
	logic [16:0]        dv_sh;
	logic               dv_ge;
	logic signed [33:0] err_w;
	logic signed [17:0] err_c;
	logic signed [19:0] vz_e;
	logic signed [23:0] vz_raw;
	logic signed [15:0] vz_sat;
	logic               in_window;

	assign xe = 17'(cur_x_q);
	assign ye = 17'(cur_y_q);
	assign abs_x = xe[16] ? 17'(-xe) : 17'(xe);
	assign abs_y = ye[16] ? 17'(-ye) : 17'(ye);
	assign kp_x = (abs_x > {2'b0, cfg.far_threshold_mm}) ? cfg.gain_far_q8 : cfg.gain_near_q8;
	assign kp_y = (abs_y > {2'b0, cfg.far_threshold_mm}) ? cfg.gain_far_q8 : cfg.gain_near_q8;
	assign dx  = 17'(cur_x_q) - 17'(prev_x_q);
	assign dy  = 17'(cur_y_q) - 17'(prev_y_q);
	assign dzp = 17'(cur_z_q) - 17'(prev_z_q);
	assign sl = slope_q[23] ? 24'sd0 : slope_q;
	assign ediff = 19'(e_q) - 19'(last_err_q);

	always_comb begin
		case (cmd.sel)
			lvc_pkg::SEL_XX: begin mul_a = 24'(cur_x_q); mul_b = 19'(cur_x_q); end
			lvc_pkg::SEL_YY: begin mul_a = 24'(cur_y_q); mul_b = 19'(cur_y_q); end
			lvc_pkg::SEL_DX: begin mul_a = 24'(dx); mul_b = 19'(dx); end
			lvc_pkg::SEL_DY: begin mul_a = 24'(dy); mul_b = 19'(dy); end
			lvc_pkg::SEL_DZ: begin mul_a = 24'(dzp); mul_b = 19'(dzp); end
			lvc_pkg::SEL_PX: begin mul_a = 24'(cur_x_q); mul_b = $signed({11'b0, kp_x}); end
			lvc_pkg::SEL_KX: begin
				mul_a = 24'(dx); mul_b = $signed({11'b0, cfg.deriv_gain_q8});
			end
			lvc_pkg::SEL_PY: begin mul_a = 24'(cur_y_q); mul_b = $signed({11'b0, kp_y}); end
			lvc_pkg::SEL_KY: begin
				mul_a = 24'(dy); mul_b = $signed({11'b0, cfg.deriv_gain_q8});
			end
			lvc_pkg::SEL_ZD: begin mul_a = sl; mul_b = $signed({3'b0, hd_q}); end
			lvc_pkg::SEL_EK: begin
				mul_a = 24'(ediff); mul_b = $signed({11'b0, cfg.deriv_gain_q8});
			end
			default: begin mul_a = 24'sd0; mul_b = 19'sd0; end
		endcase
	end

	assign prod    = mul_a * mul_b;
	assign acc_d   = (cmd.clr ? '0 : acc_q) + prod[lvc_pkg::ACC_W-1:0];
	// Round half up: floor((s + 128) / 256).
	assign acc_rnd = (acc_q + 41'sd128) >>> 8;

	assign dz     = 17'(cur_z_q) - $signed({2'b0, cfg.base_height_mm});
	assign abs_dz = dz[16] ? 17'(-dz) : 17'(dz);

	assign status.plan_go   = !plan_done_q && (acc_q < lvc_pkg::NEAR_SQ_LIMIT);
	assign status.hd_zero   = (hd_q == 16'd0);
	assign status.sqrt_last = (cnt_q == lvc_pkg::SQRT_LAST);
	assign status.div_last  = (cnt_q == lvc_pkg::DIV_LAST);

	// One root bit per step.
	assign sq_sh    = {sq_rem_q, sq_n_q[31:30]};
	assign sq_trial = {2'b0, hd_q, 2'b01};
	assign sq_ge    = (sq_sh >= sq_trial);
	assign sq_diff  = sq_sh - sq_trial;

	// One quotient bit per step.
	assign dv_sh = {drem_q, num_q[23]};
	assign dv_ge = (dv_sh >= {1'b0, hd_q});

	assign err_w = $signed({19'b0, cfg.base_height_mm}) + 34'(acc_q >>> 8) - 34'(cur_z_q);
	always_comb begin
		if (err_w > 34'(lvc_pkg::ERR_MAX)) begin
			err_c = lvc_pkg::ERR_MAX;
		end else if (err_w < 34'(lvc_pkg::ERR_MIN)) begin
			err_c = lvc_pkg::ERR_MIN;
		end else begin
			err_c = err_w[17:0];
		end
	end

	assign vz_e = 20'(e_q) + 20'(acc_rnd);
	always_comb begin
		if (land_q) begin
			vz_raw = 24'(held_z_q);
		end else if (!desc_en_q) begin
			vz_raw = 24'sd0;
		end else if (e_q[17]) begin
			vz_raw = 24'(vz_e);
		end else begin
			vz_raw = 24'(held_z_q);
		end
	end
	assign vz_sat = lvc_pkg::sat16(vz_raw, cfg.z_speed_limit);
	assign in_window = (abs_x < {2'b0, cfg.land_window_mm}) &&
		(abs_y < {2'b0, cfg.land_window_mm});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_x_q <= '0; cur_y_q <= '0; cur_z_q <= '0;
			prev_x_q <= '0; prev_y_q <= '0; prev_z_q <= '0;
			held_x_q <= '0; held_y_q <= '0; held_z_q <= '0;
			slope_q <= '0;
			last_err_q <= '0;
			desc_en_q <= 1'b0;
			plan_done_q <= 1'b0;
			land_q <= 1'b0;
		end else begin
			case (cmd.op)
				lvc_pkg::OP_LOAD: begin
					if (mode == lvc_pkg::MODE_POSE) begin
						prev_x_q <= cur_x_q; prev_y_q <= cur_y_q; prev_z_q <= cur_z_q;
						cur_x_q <= pos_x; cur_y_q <= pos_y; cur_z_q <= pos_z;
					end else if (mode == lvc_pkg::MODE_GEAR_UP) begin
						cur_x_q <= '0; cur_y_q <= '0; cur_z_q <= '0;
						held_x_q <= '0; held_y_q <= '0; held_z_q <= '0;
						slope_q <= '0;
						last_err_q <= '0;
						desc_en_q <= 1'b0;
						plan_done_q <= 1'b0;
						land_q <= 1'b0;
					end
				end
				lvc_pkg::OP_PLAN: begin
					if (status.plan_go) begin
						desc_en_q <= !dz[16] && (dz != 17'sd0);
						plan_done_q <= 1'b1;
						if (hd_q == 16'd0) begin
							if (dz[16]) begin
								slope_q <= lvc_pkg::SLOPE_MIN;
							end else if (dz != 17'sd0) begin
								slope_q <= lvc_pkg::SLOPE_MAX;
							end else begin
								slope_q <= '0;
							end
						end
					end
				end
				lvc_pkg::OP_DIV_FIN: begin
					if (!dz_neg_q) begin
						slope_q <= quo_q[23] ? lvc_pkg::SLOPE_MAX : $signed(quo_q);
					end else if (quo_q > 24'h800000) begin
						slope_q <= lvc_pkg::SLOPE_MIN;
					end else begin
						slope_q <= -$signed(quo_q);
					end
				end
				lvc_pkg::OP_VZ: begin
					held_x_q <= vx_q;
					held_y_q <= vy_q;
					held_z_q <= in_window ? lvc_pkg::LAND_VZ : vz_sat;
					if (in_window) begin
						land_q <= 1'b1;
					end
					if (!land_q && desc_en_q) begin
						last_err_q <= e_q;
					end
				end
				lvc_pkg::OP_FIN: begin
					if (!mode_q[1] && lost_q) begin
						held_x_q <= '0;
						held_y_q <= '0;
					end
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (cmd.op)
			lvc_pkg::OP_LOAD: begin
				mode_q <= mode;
				lost_q <= tag_lost;
			end
			lvc_pkg::OP_MAC: acc_q <= acc_d;
			lvc_pkg::OP_SQRT_INIT: begin
				sq_n_q <= acc_q[31:0];
				sq_rem_q <= '0;
				hd_q <= '0;
				cnt_q <= '0;
			end
			lvc_pkg::OP_SQRT_STEP: begin
				sq_rem_q <= sq_ge ? sq_diff[17:0] : sq_sh[17:0];
				hd_q <= {hd_q[14:0], sq_ge};
				sq_n_q <= {sq_n_q[29:0], 2'b00};
				cnt_q <= cnt_q + 5'd1;
			end
			lvc_pkg::OP_PLAN: begin
				num_q <= {abs_dz[15:0], 8'b0};
				drem_q <= '0;
				dz_neg_q <= dz[16];
				cnt_q <= '0;
			end
			lvc_pkg::OP_DIV_STEP: begin
				drem_q <= dv_ge ? 16'(dv_sh - {1'b0, hd_q}) : dv_sh[15:0];
				quo_q <= {quo_q[22:0], dv_ge};
				num_q <= {num_q[22:0], 1'b0};
				cnt_q <= cnt_q + 5'd1;
			end
			lvc_pkg::OP_VX: vx_q <= lvc_pkg::sat16(24'(acc_rnd), cfg.xy_speed_limit);
			lvc_pkg::OP_VY: vy_q <= lvc_pkg::sat16(24'(acc_rnd), cfg.xy_speed_limit);
			lvc_pkg::OP_ERR: e_q <= err_c;
			lvc_pkg::OP_FIN: begin
				out_x_q <= (!mode_q[1] && lost_q) ? 16'sd0 : held_x_q;
				out_y_q <= (!mode_q[1] && lost_q) ? 16'sd0 : held_y_q;
				out_z_q <= held_z_q;
				out_land_q <= land_q;
			end
			default: ;
		endcase
	end

	assign vel_x = out_x_q;
	assign vel_y = out_y_q;
	assign vel_z = out_z_q;
	assign landing_flag = out_land_q;
endmodule
`default_nettype wire

// ===== sv/lvc_ctrl.sv =====
// Sequencer that steps the datapath through one control tick.
`default_nettype none
module lvc_ctrl (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         in_valid,
	output logic              in_stall,
	input  wire logic [1:0]   mode,
	output logic              out_valid,
	input  wire logic         out_stall,
	output lvc_pkg::cmd_t     cmd,
	input  lvc_pkg::status_t  status
);
	typedef enum logic [21:0] {
		S_IDLE = 22'h000001,
		S_XX   = 22'h000002,
		S_YY   = 22'h000004,
		S_SQI  = 22'h000008,
		S_SQS  = 22'h000010,
		S_DX   = 22'h000020,
		S_DY   = 22'h000040,
		S_DZ   = 22'h000080,
		S_PLAN = 22'h000100,
		S_DVS  = 22'h000200,
		S_DVF  = 22'h000400,
		S_PX   = 22'h000800,
		S_KX   = 22'h001000,
		S_VX   = 22'h002000,
		S_PY   = 22'h004000,
		S_KY   = 22'h008000,
		S_VY   = 22'h010000,
		S_ZD   = 22'h020000,
		S_ERR  = 22'h040000,
		S_EK   = 22'h080000,
		S_VZ   = 22'h100000,
		S_FIN  = 22'h200000
	} state_t;

	state_t state_q, state_d;
	logic   out_valid_q;
	logic   fin_go;

	assign in_stall  = (state_q != S_IDLE);
	assign out_valid = out_valid_q;
	assign fin_go    = (state_q == S_FIN) && (!out_valid_q || !out_stall);

	always_comb begin
		state_d = state_q;
		cmd.op  = lvc_pkg::OP_IDLE;
		cmd.sel = lvc_pkg::SEL_XX;
		cmd.clr = 1'b0;
		case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.op = lvc_pkg::OP_LOAD;
					state_d = (mode == lvc_pkg::MODE_POSE) ? S_XX : S_FIN;
				end
			end
			S_XX: begin
				cmd.op = lvc_pkg::OP_MAC; cmd.sel = lvc_pkg::SEL_XX; cmd.clr = 1'b1;
				state_d = S_YY;
			end
			S_YY: begin
				cmd.op = lvc_pkg::OP_MAC; cmd.sel = lvc_pkg::SEL_YY;
				state_d = S_SQI;
			end
			S_SQI: begin
				cmd.op = lvc_pkg::OP_SQRT_INIT;
				state_d = S_SQS;
			end
			S_SQS: begin
				cmd.op = lvc_pkg::OP_SQRT_STEP;
				if (status.sqrt_last) begin
					state_d = S_DX;
				end
			end
			S_DX: begin
				cmd.op = lvc_pkg::OP_MAC; cmd.sel = lvc_pkg::SEL_DX; cmd.clr = 1'b1;
				state_d = S_DY;
			end
			S_DY: begin
				cmd.op = lvc_pkg::OP_MAC; cmd.sel = lvc_pkg::SEL_DY;
				state_d = S_DZ;
			end
			S_DZ: begin
				cmd.op = lvc_pkg::OP_MAC; cmd.sel = lvc_pkg::SEL_DZ;
				state_d = S_PLAN;
			end
			S_PLAN: begin
				cmd.op = lvc_pkg::OP_PLAN;
				state_d = (status.plan_go && !status.hd_zero) ? S_DVS : S_PX;
			end
			S_DVS: begin
				cmd.op = lvc_pkg::OP_DIV_STEP;
				if (status.div_last) begin
					state_d = S_DVF;
				end
			end
			S_DVF: begin
				cmd.op = lvc_pkg::OP_DIV_FIN;
				state_d = S_PX;
			end
			S_PX: begin
				cmd.op = lvc_pkg::OP_MAC; cmd.sel = lvc_pkg::SEL_PX; cmd.clr = 1'b1;
				state_d = S_KX;
			end
			S_KX: begin
				cmd.op = lvc_pkg::OP_MAC; cmd.sel = lvc_pkg::SEL_KX;
				state_d = S_VX;
			end
			S_VX: begin
				cmd.op = lvc_pkg::OP_VX;
				state_d = S_PY;
			end
			S_PY: begin
				cmd.op = lvc_pkg::OP_MAC; cmd.sel = lvc_pkg::SEL_PY; cmd.clr = 1'b1;
				state_d = S_KY;
			end
			S_KY: begin
				cmd.op = lvc_pkg::OP_MAC; cmd.sel = lvc_pkg::SEL_KY;
				state_d = S_VY;
			end
			S_VY: begin
				cmd.op = lvc_pkg::OP_VY;
				state_d = S_ZD;
			end
			S_ZD: begin
				cmd.op = lvc_pkg::OP_MAC; cmd.sel = lvc_pkg::SEL_ZD; cmd.clr = 1'b1;
				state_d = S_ERR;
			end
			S_ERR: begin
				cmd.op = lvc_pkg::OP_ERR;
				state_d = S_EK;
			end
			S_EK: begin
				cmd.op = lvc_pkg::OP_MAC; cmd.sel = lvc_pkg::SEL_EK; cmd.clr = 1'b1;
				state_d = S_VZ;
			end
			S_VZ: begin
				cmd.op = lvc_pkg::OP_VZ;
				state_d = S_FIN;
			end
			S_FIN: begin
				// Wait until the output register is free.
				if (fin_go) begin
					cmd.op = lvc_pkg::OP_FIN;
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (fin_go) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end
endmodule
`default_nettype wire

// ===== sv/landing_velocity_controller.sv =====
// Landing velocity controller top level.
// Usage:
//  The input channel (in_valid / in_stall) carries one control tick: mode,
//  pos_x, pos_y, pos_z and tag_lost. A transfer happens at a rising edge with
//  in_valid high and in_stall low. Each tick yields exactly one result on the
//  output channel (out_valid / out_stall): vel_x, vel_y, vel_z, landing_flag.
//  A tick with a new pose runs the square root and, when the glide slope is
//  planned from a nonzero distance, the divider; other ticks skip both. Both
//  deliver one bit per cycle on a shared sequencer with one multiply-accumulate
//  unit. One tick is in work at a time, so the next tick is taken at the
//  earliest in the cycle its predecessor's result becomes available.
//  The result sits in an output register, so the next tick is taken while an
//  earlier result waits; if the receiver stalls, the block holds its next
//  result in its final step until the output register frees up.
//  Reset clears the model state and the sequencer and loads the register defaults.
//  Registers are written over the APB-style port at byte address 4*index;
//  the user must write them only while the block is idle, as the block leaves that to the user.
`default_nettype none
module landing_velocity_controller (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               psel,
	input  wire logic               penable,
	input  wire logic               pwrite,
	input  wire logic [4:0]         paddr,
	input  wire logic [31:0]        pwdata,
	output logic [31:0]             prdata,
	output logic                    pready,
	input  wire logic               in_valid,
	output logic                    in_stall,
	input  wire logic [1:0]         mode,
	input  wire logic signed [15:0] pos_x,
	input  wire logic signed [15:0] pos_y,
	input  wire logic signed [15:0] pos_z,
	input  wire logic               tag_lost,
	output logic                    out_valid,
	input  wire logic               out_stall,
	output logic signed [15:0]      vel_x,
	output logic signed [15:0]      vel_y,
	output logic signed [15:0]      vel_z,
	output logic                    landing_flag
);
	lvc_pkg::cfg_t    cfg;
	lvc_pkg::cmd_t    cmd;
	lvc_pkg::status_t status;

	lvc_regs u_regs (
		.clk(clk), .arst_n(arst_n), .psel(psel), .penable(penable), .pwrite(pwrite),
		.paddr(paddr), .pwdata(pwdata), .prdata(prdata), .pready(pready), .cfg(cfg)
	);

	lvc_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_stall(in_stall),
		.mode(mode), .out_valid(out_valid), .out_stall(out_stall),
		.cmd(cmd), .status(status)
	);

	lvc_datapath u_dp (
		.clk(clk), .arst_n(arst_n), .cmd(cmd), .status(status), .cfg(cfg),
		.mode(mode), .pos_x(pos_x), .pos_y(pos_y), .pos_z(pos_z), .tag_lost(tag_lost),
		.vel_x(vel_x), .vel_y(vel_y), .vel_z(vel_z), .landing_flag(landing_flag)
	);
endmodule
`default_nettype wire

// ===== tb/lvc_checker.sv =====
// Watches the landing velocity controller's channels, predicts each command and compares.
`timescale 1ns / 100ps
module lvc_checker (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               psel,
	input  wire logic               penable,
	input  wire logic               pwrite,
	input  wire logic               pready,
	input  wire logic [4:0]         paddr,
	input  wire logic [31:0]        pwdata,
	input  wire logic               in_valid,
	input  wire logic               in_stall,
	input  wire logic [1:0]         mode,
	input  wire logic signed [15:0] pos_x,
	input  wire logic signed [15:0] pos_y,
	input  wire logic signed [15:0] pos_z,
	input  wire logic               tag_lost,
	input  wire logic               out_valid,
	input  wire logic               out_stall,
	input  wire logic signed [15:0] vel_x,
	input  wire logic signed [15:0] vel_y,
	input  wire logic signed [15:0] vel_z,
	input  wire logic               landing_flag,
	output int                      fail_count,
	output int                      pending,
	output int                      cmd_count,
	output int                      land_count
);
	typedef struct {
		logic signed [15:0] vx;
		logic signed [15:0] vy;
		logic signed [15:0] vz;
		logic               flag;
	} vel_cmd_t;

	vel_cmd_t expected_cmds[$];

	lvc_pkg::cfg_t cfg;
	longint cur_p[3];
	longint prev_p[3];
	longint held_v[3];
	longint slope_q8;
	longint last_err;
	bit     descent_on;
	bit     planned;
	bit     landed;

	assign pending = expected_cmds.size();

	function automatic longint clip(longint v, longint lo, longint hi);
		return v < lo ? lo : (v > hi ? hi : v);
	endfunction

	function automatic longint iabs(longint v);
		return v < 0 ? -v : v;
	endfunction

	// Rounds a q8 sum half up: floor((s + 128) / 256).
	function automatic longint q8_round(longint s);
		return (s + 128) >>> 8;
	endfunction

	function automatic longint floor_sqrt(longint unsigned n);
		longint unsigned res;
		longint unsigned b;
		res = 0;
		b = 64'd1 << 62;
		while (b > n) b = b >> 2;
		while (b != 0) begin
			if (n >= res + b) begin
				n = n - (res + b);
				res = (res >> 1) + b;
			end else begin
				res = res >> 1;
			end
			b = b >> 2;
		end
		return longint'(res);
	endfunction

	function automatic longint pd_axis(int a);
		longint p;
		longint kp;
		p = cur_p[a];
		kp = iabs(p) > longint'(cfg.far_threshold_mm) ? longint'(cfg.gain_far_q8)
			: longint'(cfg.gain_near_q8);
		return q8_round(p * kp + (p - prev_p[a]) * longint'(cfg.deriv_gain_q8));
	endfunction

	task automatic take_pose(longint px, longint py, longint pz);
		longint hd;
		longint dsq;
		longint t;
		longint dz;
		longint vz;
		longint sl;
		longint zd;
		longint e;
		longint base;
		longint win;
		base = longint'(cfg.base_height_mm);
		win = longint'(cfg.land_window_mm);
		for (int i = 0; i < 3; i++) prev_p[i] = cur_p[i];
		cur_p[0] = px;
		cur_p[1] = py;
		cur_p[2] = pz;
		hd = floor_sqrt(longint'(px * px + py * py));
		if (!planned) begin
			dsq = 0;
			for (int i = 0; i < 3; i++) begin
				t = cur_p[i] - prev_p[i];
				dsq += t * t;
			end
			if (dsq < 600000) begin
				dz = pz - base;
				if (hd == 0)
					slope_q8 = dz > 0 ? 8388607 : (dz < 0 ? -8388608 : 0);
				else
					slope_q8 = clip(dz * 256 / hd, -8388608, 8388607);
				descent_on = dz > 0;
				planned = 1;
			end
		end
		held_v[0] = pd_axis(0);
		held_v[1] = pd_axis(1);
		vz = held_v[2];
		if (!landed) begin
			if (descent_on) begin
				sl = slope_q8 < 0 ? 0 : slope_q8;
				zd = base + (hd * sl) / 256;
				e = clip(zd - pz, -131072, 131071);
				if (e < 0)
					vz = e + q8_round((e - last_err) * longint'(cfg.deriv_gain_q8));
				last_err = e;
			end else begin
				vz = 0;
			end
		end
		held_v[0] = clip(held_v[0], -longint'(cfg.xy_speed_limit), cfg.xy_speed_limit);
		held_v[1] = clip(held_v[1], -longint'(cfg.xy_speed_limit), cfg.xy_speed_limit);
		held_v[2] = clip(vz, -longint'(cfg.z_speed_limit), cfg.z_speed_limit);
		if (iabs(px) < win && iabs(py) < win) begin
			held_v[2] = -400;
			landed = 1;
		end
	endtask

	task automatic predict_tick();
		vel_cmd_t c;
		if (mode == lvc_pkg::MODE_GEAR_UP) begin
			for (int i = 0; i < 3; i++) begin
				held_v[i] = 0;
				cur_p[i] = 0;
			end
			landed = 0;
			planned = 0;
			descent_on = 0;
			slope_q8 = 0;
			last_err = 0;
		end else if (mode != lvc_pkg::MODE_HOLD) begin
			if (mode == lvc_pkg::MODE_POSE) take_pose(pos_x, pos_y, pos_z);
			if (tag_lost) begin
				held_v[0] = 0;
				held_v[1] = 0;
			end
		end
		c.vx = held_v[0][15:0];
		c.vy = held_v[1][15:0];
		c.vz = held_v[2][15:0];
		c.flag = landed;
		expected_cmds.push_back(c);
	endtask

	task automatic write_cfg(logic [2:0] idx, logic [31:0] v);
		case (lvc_pkg::reg_idx_t'(idx))
			lvc_pkg::REG_FAR_THRESHOLD: cfg.far_threshold_mm = v[14:0];
			lvc_pkg::REG_GAIN_NEAR:     cfg.gain_near_q8 = v[7:0];
			lvc_pkg::REG_GAIN_FAR:      cfg.gain_far_q8 = v[7:0];
			lvc_pkg::REG_DERIV_GAIN:    cfg.deriv_gain_q8 = v[7:0];
			lvc_pkg::REG_XY_LIMIT:      cfg.xy_speed_limit = v[14:0];
			lvc_pkg::REG_Z_LIMIT:       cfg.z_speed_limit = v[14:0];
			lvc_pkg::REG_LAND_WINDOW:   cfg.land_window_mm = v[14:0];
			lvc_pkg::REG_BASE_HEIGHT:   cfg.base_height_mm = v[14:0];
			default: ;
		endcase
	endtask

	task automatic check_cmd();
		vel_cmd_t c;
		if (expected_cmds.size() == 0) begin
			fail_count++;
			if (fail_count <= 10)
				$display("unexpected command transfer: vx=%0d vy=%0d vz=%0d flag=%0d",
					vel_x, vel_y, vel_z, landing_flag);
			return;
		end
		c = expected_cmds.pop_front();
		cmd_count++;
		if (landing_flag) land_count++;
		if (c.vx !== vel_x || c.vy !== vel_y || c.vz !== vel_z || c.flag !== landing_flag) begin
			fail_count++;
			if (fail_count <= 10)
				$display({"command %0d mismatch: expected vx=%0d vy=%0d vz=%0d flag=%0d,",
					" got vx=%0d vy=%0d vz=%0d flag=%0d"},
					cmd_count, c.vx, c.vy, c.vz, c.flag, vel_x, vel_y, vel_z, landing_flag);
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg.far_threshold_mm = lvc_pkg::FAR_THRESHOLD_RST;
			cfg.gain_near_q8 = lvc_pkg::GAIN_NEAR_RST;
			cfg.gain_far_q8 = lvc_pkg::GAIN_FAR_RST;
			cfg.deriv_gain_q8 = lvc_pkg::DERIV_GAIN_RST;
			cfg.xy_speed_limit = lvc_pkg::XY_LIMIT_RST;
			cfg.z_speed_limit = lvc_pkg::Z_LIMIT_RST;
			cfg.land_window_mm = lvc_pkg::LAND_WINDOW_RST;
			cfg.base_height_mm = lvc_pkg::BASE_HEIGHT_RST;
			for (int i = 0; i < 3; i++) begin
				cur_p[i] = 0;
				prev_p[i] = 0;
				held_v[i] = 0;
			end
			slope_q8 = 0;
			last_err = 0;
			descent_on = 0;
			planned = 0;
			landed = 0;
			expected_cmds.delete();
			fail_count = 0;
			cmd_count = 0;
			land_count = 0;
		end else begin
			if (psel && penable && pwrite && pready) write_cfg(paddr[4:2], pwdata);
			if (out_valid && !out_stall) check_cmd();
			if (in_valid && !in_stall) predict_tick();
		end
	end
endmodule

// ===== tb/tb_top.sv =====
// Stimulus and verdict for the landing velocity controller testbench.
`timescale 1ns / 100ps
module tb_top;
	localparam int CYCLE_LIMIT = 400000;

	logic               clk;
	logic               arst_n;
	logic               psel;
	logic               penable;
	logic               pwrite;
	logic [4:0]         paddr;
	logic [31:0]        pwdata;
	logic [31:0]        prdata;
	logic               pready;
	logic               in_valid;
	logic               in_stall;
	logic [1:0]         mode;
	logic signed [15:0] pos_x;
	logic signed [15:0] pos_y;
	logic signed [15:0] pos_z;
	logic               tag_lost;
	logic               out_valid;
	logic               out_stall;
	logic signed [15:0] vel_x;
	logic signed [15:0] vel_y;
	logic signed [15:0] vel_z;
	logic               landing_flag;

	int fail_count;
	int pending;
	int cmd_count;
	int land_count;
	int cycles = 0;
	bit no_idle;
	int last_x;
	int last_y;
	int last_z;

	landing_velocity_controller uut (.*);

	lvc_checker u_checker (
		.clk(clk), .arst_n(arst_n), .psel(psel), .penable(penable), .pwrite(pwrite),
		.pready(pready), .paddr(paddr), .pwdata(pwdata), .in_valid(in_valid),
		.in_stall(in_stall), .mode(mode), .pos_x(pos_x), .pos_y(pos_y), .pos_z(pos_z),
		.tag_lost(tag_lost), .out_valid(out_valid), .out_stall(out_stall),
		.vel_x(vel_x), .vel_y(vel_y), .vel_z(vel_z), .landing_flag(landing_flag),
		.fail_count(fail_count), .pending(pending), .cmd_count(cmd_count),
		.land_count(land_count)
	);

	initial begin
		clk = 0;
		forever #5 clk = ~clk;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("[landing_velocity_controller] ERROR");
			$finish;
		end
	end

	function automatic int idle_draw();
		return no_idle ? 0 : $urandom_range(0, 16);
	endfunction

	// Receiver: stalls a random number of cycles before each result transfer.
	initial begin : receiver
		int n;
		out_stall = 1'b0;
		@(posedge arst_n);
		forever begin
			n = idle_draw();
			if (n > 0) begin
				out_stall <= 1'b1;
				repeat (n) @(posedge clk);
			end
			out_stall <= 1'b0;
			do @(posedge clk); while (!out_valid);
		end
	end

	task automatic send_tick(logic [1:0] m, int x, int y, int z, logic lost);
		int gap;
		gap = idle_draw();
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		mode <= m;
		pos_x <= 16'(x);
		pos_y <= 16'(y);
		pos_z <= 16'(z);
		tag_lost <= lost;
		do @(posedge clk); while (in_stall);
	endtask

	task automatic pose(int x, int y, int z);
		send_tick(lvc_pkg::MODE_POSE, x, y, z, 1'b0);
	endtask

	task automatic write_reg(lvc_pkg::reg_idx_t idx, logic [31:0] v);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= v;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
	endtask

	// Lets every outstanding command arrive, then a tick's worth of cycles more.
	task automatic drain();
		in_valid <= 1'b0;
		while (pending != 0) @(posedge clk);
		repeat (70) @(posedge clk);
	endtask

	task automatic load_cfg(int far, int kn, int kf, int kd, int xyl, int zl, int win,
		int base);
		write_reg(lvc_pkg::REG_FAR_THRESHOLD, far);
		write_reg(lvc_pkg::REG_GAIN_NEAR, kn);
		write_reg(lvc_pkg::REG_GAIN_FAR, kf);
		write_reg(lvc_pkg::REG_DERIV_GAIN, kd);
		write_reg(lvc_pkg::REG_XY_LIMIT, xyl);
		write_reg(lvc_pkg::REG_Z_LIMIT, zl);
		write_reg(lvc_pkg::REG_LAND_WINDOW, win);
		write_reg(lvc_pkg::REG_BASE_HEIGHT, base);
	endtask

	function automatic int clip16(int v);
		return v > 32767 ? 32767 : (v < -32768 ? -32768 : v);
	endfunction

	// Mostly an approach: poses close to the previous one so the slope gets
	// planned and the descent runs; the rest is gear up, idle ticks and jumps.
	task automatic random_tick();
		int r;
		logic lost;
		r = $urandom_range(0, 99);
		lost = ($urandom_range(0, 9) == 0);
		if (r < 6) begin
			send_tick(lvc_pkg::MODE_GEAR_UP, $urandom, $urandom, $urandom, lost);
			last_x = int'($urandom_range(0, 12000)) - 6000;
			last_y = int'($urandom_range(0, 12000)) - 6000;
			last_z = int'($urandom_range(0, 12000)) - 2000;
		end else if (r < 16) begin
			send_tick(lvc_pkg::MODE_TICK, $urandom, $urandom, $urandom, lost);
		end else if (r < 19) begin
			send_tick(lvc_pkg::MODE_HOLD, $urandom, $urandom, $urandom, lost);
		end else begin
			if (r < 31) begin
				last_x = $signed(16'($urandom));
				last_y = $signed(16'($urandom));
				last_z = $signed(16'($urandom));
			end else begin
				last_x = clip16(last_x * 7 / 8 + int'($urandom_range(0, 600)) - 300);
				last_y = clip16(last_y * 7 / 8 + int'($urandom_range(0, 600)) - 300);
				last_z = clip16(last_z + int'($urandom_range(0, 600)) - 300);
			end
			send_tick(lvc_pkg::MODE_POSE, last_x, last_y, last_z, lost);
		end
	endtask

	initial begin
		arst_n = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		in_valid = 1'b0;
		mode = lvc_pkg::MODE_TICK;
		pos_x = '0;
		pos_y = '0;
		pos_z = '0;
		tag_lost = 1'b0;
		no_idle = 1'b0;
		last_x = 0;
		last_y = 0;
		last_z = 5000;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		load_cfg(4800, 33, 128, 26, 1500, 1000, 100, 3000);
		// Directed: extremes, every mode, lost tag, zero distance, tiny slope.
		send_tick(lvc_pkg::MODE_GEAR_UP, 0, 0, 0, 1'b0);
		pose(0, 0, 0);
		send_tick(lvc_pkg::MODE_GEAR_UP, -1, -1, -1, 1'b1);
		pose(32767, 32767, 32767);
		pose(-32768, -32768, -32768);
		send_tick(lvc_pkg::MODE_TICK, 0, 0, 0, 1'b1);
		send_tick(lvc_pkg::MODE_HOLD, -1, -1, -1, 1'b1);
		send_tick(lvc_pkg::MODE_GEAR_UP, 0, 0, 0, 1'b0);
		pose(2000, 1000, 5000);
		pose(2000, 1000, 5000);
		pose(1500, 800, 9000);
		pose(1200, 600, 9500);
		send_tick(lvc_pkg::MODE_POSE, 900, 400, 9000, 1'b1);
		send_tick(lvc_pkg::MODE_TICK, 0, 0, 0, 1'b0);
		pose(50, -50, 4000);
		pose(40, -40, 9000);
		send_tick(lvc_pkg::MODE_GEAR_UP, 0, 0, 0, 1'b0);
		pose(0, 0, 5000);
		pose(0, 0, 5000);
		send_tick(lvc_pkg::MODE_GEAR_UP, 0, 0, 0, 1'b0);
		pose(20000, 0, 3001);
		pose(20000, 0, 3001);
		pose(19000, 0, 3100);
		send_tick(lvc_pkg::MODE_GEAR_UP, 0, 0, 0, 1'b0);
		drain();

		for (int ph = 0; ph < 5; ph++) begin
			case (ph)
				0: load_cfg(4800, 33, 128, 26, 1500, 1000, 100, 3000);
				1: load_cfg(32767, 255, 255, 255, 32767, 32767, 32767, 32767);
				2: load_cfg(0, 0, 0, 0, 0, 0, 0, 0);
				3: load_cfg($urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
					$urandom_range(0, 400), $urandom_range(0, 8000));
				default: load_cfg($urandom_range(0, 9000), $urandom, $urandom, $urandom,
					$urandom_range(0, 3000), $urandom_range(0, 3000), $urandom_range(0, 300),
					$urandom_range(0, 6000));
			endcase
			for (int i = 0; i < 110; i++) begin
				if (i % 40 == 0) no_idle = ($urandom_range(0, 2) == 0);
				random_tick();
			end
			no_idle = 1'b0;
			drain();
		end

		$display("Checked %0d velocity commands (%0d with the landing flag),",
			cmd_count, land_count);
		$display("covering directed edge poses and five register setups under random stalls.");
		if (fail_count == 0) begin
			$display("[landing_velocity_controller] OK");
		end else begin
			$display("%0d mismatches", fail_count);
			$display("[landing_velocity_controller] ERROR");
		end
		$finish;
	end
endmodule
